// File: rtl/core/saw_pkg.sv
`timescale 1ns / 1ps
// saw_pkg: shared constants, codes and structs of the stop-and-wait sender
// no dependencies; used by saw_fifo, saw_core and the top level
package saw_pkg;

  localparam int QDEPTH    = 16;
  localparam int REF_W     = 16;
  localparam int SEQ_W     = 16;
  localparam int CNT_W     = 32;
  localparam int RETRY_W   = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam logic [RETRY_W-1:0] RETRY_MAX = {RETRY_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_SENDING = 2'd1,
    ST_WAITING = 2'd2
  } saw_state_t;

  typedef enum logic [1:0] {
    ACT_NEW  = 2'd0,
    ACT_DONE = 2'd1,
    ACT_ACK  = 2'd2,
    ACT_NACK = 2'd3
  } saw_action_t;

  typedef struct packed {
    saw_action_t      action;
    logic [REF_W-1:0] packet_ref;
    logic [SEQ_W-1:0] reply_seq;
  } saw_item_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [REF_W-1:0] wdata;
  } saw_fifo_ctl_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic [REF_W-1:0]  head;
  } saw_fifo_stat_t;

  typedef struct packed {
    logic               transmit;
    logic [REF_W-1:0]   tx_packet_ref;
    logic [SEQ_W-1:0]   tx_seq;
    logic [RETRY_W-1:0] transmit_count;
    logic [QCNT_W-1:0]  queue_level;
    logic [CNT_W-1:0]   acks_received;
    logic [CNT_W-1:0]   nacks_received;
    saw_state_t         sender_state;
    logic               dropped;
  } saw_result_t;

endpackage

// File: rtl/core/saw_fifo.sv
`timescale 1ns / 1ps
// saw_fifo: pending-packet queue, flop storage with head read
// depends on saw_pkg
module saw_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  saw_pkg::saw_fifo_ctl_t  ctl,
  output saw_pkg::saw_fifo_stat_t stat
);

  logic [saw_pkg::REF_W-1:0]  store_r [saw_pkg::QDEPTH];
  logic [saw_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [saw_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [saw_pkg::QCNT_W-1:0] count_r, count_nxt;

  localparam logic [saw_pkg::QPTR_W-1:0] PTR_LAST = saw_pkg::QPTR_W'(saw_pkg::QDEPTH - 1);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage needs no reset, entries are read only after being written
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      store_r[wr_ptr_r] <= ctl.wdata;
    end
  end

  assign stat.count = count_r;
  assign stat.head  = store_r[rd_ptr_r];

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> (count_r < saw_pkg::QCNT_W'(saw_pkg::QDEPTH)))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> (count_r != '0))
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && !ctl.pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

// File: rtl/core/saw_core.sv
`timescale 1ns / 1ps
// saw_core: sender state machine, sequence and retry tracking, counters
// depends on saw_pkg; drives the push/pop controls of saw_fifo
module saw_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  saw_pkg::saw_item_t      item,
  input  saw_pkg::saw_fifo_stat_t fstat,
  output saw_pkg::saw_fifo_ctl_t  fctl,
  output saw_pkg::saw_result_t    result
);

  saw_pkg::saw_state_t            state_r, state_nxt;
  logic [saw_pkg::REF_W-1:0]      ref_r, ref_nxt;
  logic [saw_pkg::SEQ_W-1:0]      seq_r, seq_nxt;
  logic [saw_pkg::RETRY_W-1:0]    retry_r, retry_nxt;
  logic [saw_pkg::CNT_W-1:0]      acks_r, acks_nxt;
  logic [saw_pkg::CNT_W-1:0]      nacks_r, nacks_nxt;

  logic                           match;
  logic                           start_new, resend, go_wait, go_idle;
  logic                           ack_hit, nack_hit, push, pop, drop;
  logic [saw_pkg::REF_W-1:0]      new_ref;

  assign match = (state_r != saw_pkg::ST_IDLE) && (item.reply_seq == seq_r);

  // event decode
  always_comb begin
    start_new = 1'b0;
    resend    = 1'b0;
    go_wait   = 1'b0;
    go_idle   = 1'b0;
    ack_hit   = 1'b0;
    nack_hit  = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    drop      = 1'b0;
    new_ref   = item.packet_ref;
    if (fire) begin
      unique case (item.action)
        saw_pkg::ACT_NEW: begin
          if (state_r == saw_pkg::ST_IDLE) begin
            start_new = 1'b1;
          end else if (fstat.count < saw_pkg::QCNT_W'(saw_pkg::QDEPTH)) begin
            push = 1'b1;
          end else begin
            drop = 1'b1;
          end
        end
        saw_pkg::ACT_DONE: begin
          go_wait = (state_r == saw_pkg::ST_SENDING);
        end
        saw_pkg::ACT_ACK: begin
          if (match) begin
            ack_hit = 1'b1;
            if (fstat.count == '0) begin
              go_idle = 1'b1;
            end else begin
              pop       = 1'b1;
              start_new = 1'b1;
              new_ref   = fstat.head;
            end
          end
        end
        saw_pkg::ACT_NACK: begin
          if (match) begin
            nack_hit = 1'b1;
            resend   = 1'b1;
          end
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    priority if (start_new || resend) begin
      state_nxt = saw_pkg::ST_SENDING;
    end else if (go_idle) begin
      state_nxt = saw_pkg::ST_IDLE;
    end else if (go_wait) begin
      state_nxt = saw_pkg::ST_WAITING;
    end
  end

  // datapath next values and result
  always_comb begin
    ref_nxt   = start_new ? new_ref : ref_r;
    seq_nxt   = start_new ? seq_r + 1'b1 : seq_r;
    acks_nxt  = ack_hit ? acks_r + 1'b1 : acks_r;
    nacks_nxt = nack_hit ? nacks_r + 1'b1 : nacks_r;
    priority if (start_new) begin
      retry_nxt = saw_pkg::RETRY_W'(1);
    end else if (resend) begin
      retry_nxt = (retry_r == saw_pkg::RETRY_MAX) ? retry_r : retry_r + 1'b1;
    end else if (ack_hit) begin
      retry_nxt = '0;
    end else begin
      retry_nxt = retry_r;
    end

    fctl.push  = push;
    fctl.pop   = pop;
    fctl.wdata = item.packet_ref;

    result.transmit       = start_new || resend;
    result.tx_packet_ref  = (start_new || resend) ? ref_nxt : '0;
    result.tx_seq         = (start_new || resend) ? seq_nxt : '0;
    result.transmit_count = retry_nxt;
    result.queue_level    = fstat.count;
    result.acks_received  = acks_nxt;
    result.nacks_received = nacks_nxt;
    result.sender_state   = state_nxt;
    result.dropped        = drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= saw_pkg::ST_IDLE;
      ref_r   <= '0;
      seq_r   <= '0;
      retry_r <= '0;
      acks_r  <= '0;
      nacks_r <= '0;
    end else begin
      state_r <= state_nxt;
      ref_r   <= ref_nxt;
      seq_r   <= seq_nxt;
      retry_r <= retry_nxt;
      acks_r  <= acks_nxt;
      nacks_r <= nacks_nxt;
    end
  end

`ifndef SYNTH
  a_tx_enters_sending: assert property (@(posedge clk) disable iff (!rst_n)
    (start_new || resend) |=> (state_r == saw_pkg::ST_SENDING))
    else $error("transmit without entering sending");
  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop |-> (fstat.count == saw_pkg::QCNT_W'(saw_pkg::QDEPTH)))
    else $error("packet dropped with room in queue");
  a_idle_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == saw_pkg::ST_IDLE) |-> !pop && !resend)
    else $error("queue pop or resend while idle");
`endif

endmodule

// File: rtl/core/stop_and_wait_arq_sender_top.sv
`timescale 1ns / 1ps
// stop_and_wait_arq_sender_top: input register, sender core, result register
// depends on saw_pkg, saw_fifo and saw_core
//
// usage
//   input channel: in_valid / in_stall carry one event word per handshake
//     (in_action: new packet, transmit done, ack, nack; in_packet_ref for
//     a new packet; in_reply_seq for an ack or nack)
//   result channel: out_valid / out_stall return exactly one result word
//     per event, in event order
//   path: an accepted event goes to the input register, its result to the
//     result register; throughput one event per cycle without out_stall,
//     set by the state update between the two registers
//   the pending queue holds 16 packet handles in flops, head read directly
//   reset: synchronous, active low; clears the state machine to idle, the
//     sequence number, retry count, ack/nack counters, queue pointers and
//     both valid flags; queue contents are not cleared
//   stall: while out_stall holds a valid result, the result register and
//     the sender state freeze; one more event is held in the input register
//     and in_stall rises only when that register is also occupied
module stop_and_wait_arq_sender_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_packet_ref,
  input  logic [15:0] in_reply_seq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_transmit,
  output logic [15:0] out_tx_packet_ref,
  output logic [15:0] out_tx_seq,
  output logic [7:0]  out_transmit_count,
  output logic [4:0]  out_queue_level,
  output logic [31:0] out_acks_received,
  output logic [31:0] out_nacks_received,
  output logic [1:0]  out_sender_state,
  output logic        out_dropped
);

  saw_pkg::saw_item_t      item_r;
  logic                    item_valid_r;
  saw_pkg::saw_result_t    res_r;
  saw_pkg::saw_result_t    res_nxt;
  logic                    out_valid_r;
  saw_pkg::saw_fifo_ctl_t  fctl;
  saw_pkg::saw_fifo_stat_t fstat;

  logic advance;   // result register can take a new word
  logic fire;      // held event is processed this cycle
  logic in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = item_valid_r && advance;
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (fire) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action     <= saw_pkg::saw_action_t'(in_action);
      item_r.packet_ref <= in_packet_ref;
      item_r.reply_seq  <= in_reply_seq;
    end
  end

  saw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fctl),
    .stat  (fstat)
  );

  saw_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .fstat  (fstat),
    .fctl   (fctl),
    .result (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_transmit       = res_r.transmit;
  assign out_tx_packet_ref  = res_r.tx_packet_ref;
  assign out_tx_seq         = res_r.tx_seq;
  assign out_transmit_count = res_r.transmit_count;
  assign out_queue_level    = res_r.queue_level;
  assign out_acks_received  = res_r.acks_received;
  assign out_nacks_received = res_r.nacks_received;
  assign out_sender_state   = res_r.sender_state;
  assign out_dropped        = res_r.dropped;

`ifndef SYNTH
  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed event did not reach result register");
  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> item_valid_r && $stable(item_r))
    else $error("held event lost while stalled");
  a_tx_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.transmit) |-> (res_r.sender_state == saw_pkg::ST_SENDING))
    else $error("transmit reported outside sending state");
`endif

endmodule
